// ===== hw/rtl/hbr_pkg.sv =====
package hbr_pkg;

	localparam int WORD_W    = 64;
	localparam int IN_WORDS  = 4;
	localparam int DIST_W    = 9;
	localparam int ID_W      = 12;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 9;
	localparam int WQ_DEPTH  = 4;
	localparam int WQ_PTR_W  = 2;
	localparam int WQ_CNT_W  = 3;

	localparam logic [DIST_W-1:0] DIST_MAX = 9'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 8'd1;

	localparam logic [CFG_W-1:0] RATIO_RESET  = 9'd179;
	localparam logic [CFG_W-1:0] THRESH_RESET = 9'd50;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_CAND = 1'b1
	} cmd_t;

	// Classified item passed from the front end to the search back end
	typedef struct packed {
		cmd_t              kind;
		logic [DIST_W-1:0] hdist;
		logic [ID_W-1:0]   id;
		logic              last;
	} work_t;

	typedef struct packed {
		logic              match;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] best;
		logic [DIST_W-1:0] second;
	} result_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

	// Byte counts summed as a balanced tree
	function automatic logic [CNT_W-1:0] pop64(input logic [WORD_W-1:0] v);
		logic [4:0] p2 [4];
		logic [5:0] p4 [2];
		for (int i = 0; i < 4; i++) begin
			p2[i] = {1'b0, pop8(v[16*i +: 8])} + {1'b0, pop8(v[16*i+8 +: 8])};
		end
		for (int i = 0; i < 2; i++) begin
			p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
		end
		return {1'b0, p4[0]} + {1'b0, p4[1]};
	endfunction

endpackage

// ===== hw/rtl/best_two_hamming_ratio_match_top.sv =====
// Channel   Direction  Handshake               Carries
// input     in         push / full             cmd, word0..word3, cand_id, last
// result    out        empty / pop             match_found, best_id, best_distance,
//                                              second_distance
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Takes one item per cycle while full is low; full rises only when the work queue and the two
// popcount stages together hold WQ_DEPTH items. A candidate reaches the search unit through
// both popcount stages and the work queue; a list's result passes the finishing and result registers.
// Reset clears the query and the search state, and loads ratio_q8 179, threshold 50.
// A closing candidate stalls at the queue head only while both the finishing
// stage and the result register are occupied; the queue then backs up to full.
module best_two_hamming_ratio_match_top import hbr_pkg::*; #(
	parameter int DESC_WORDS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 cmd,
	input  logic [WORD_W-1:0]    word0,
	input  logic [WORD_W-1:0]    word1,
	input  logic [WORD_W-1:0]    word2,
	input  logic [WORD_W-1:0]    word3,
	input  logic [ID_W-1:0]      cand_id,
	input  logic                 last,
	output logic                 empty,
	input  logic                 pop,
	output logic                 match_found,
	output logic [ID_W-1:0]      best_id,
	output logic [DIST_W-1:0]    best_distance,
	output logic [DIST_W-1:0]    second_distance,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic                take;
	logic                wq_push;
	work_t               wq_in;
	work_t               wq_out;
	logic                wq_pop;
	logic [WQ_CNT_W-1:0] wq_count;
	logic [1:0]          inflight;
	logic [WQ_CNT_W-1:0] occupancy;
	logic                res_valid;
	logic                res_pop;
	result_t             res;
	logic [CFG_W-1:0]    ratio_q;
	logic [CFG_W-1:0]    thresh_q;

	// Count items in the popcount stages against the queue space (credit)
	assign occupancy = wq_count + {1'b0, inflight};
	assign full      = (occupancy >= WQ_CNT_W'(WQ_DEPTH));
	assign take      = push && !full;

	// Config regs: always ready; write them only while no item is in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RATIO:  ratio_q  <= cfg_data;
				CFG_THRESH: thresh_q <= cfg_data;
				default:    ratio_q  <= ratio_q;
			endcase
		end
	end

	// Front end: hold the query, XOR and popcount each candidate
	hbr_front #(
		.DESC_WORDS(DESC_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.cmd      (cmd_t'(cmd)),
		.word0    (word0),
		.word1    (word1),
		.word2    (word2),
		.word3    (word3),
		.cand_id  (cand_id),
		.last     (last),
		.wq_push  (wq_push),
		.wq_item  (wq_in),
		.inflight (inflight)
	);

	// Decouple the front end from the search unit
	hbr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.din    (wq_in),
		.pop    (wq_pop),
		.dout   (wq_out),
		.count  (wq_count)
	);

	// Back end: track best two, close the list, apply ratio and threshold
	hbr_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.wq_empty           (wq_count == '0),
		.wq_item            (wq_out),
		.wq_pop             (wq_pop),
		.ratio_q8           (ratio_q),
		.distance_threshold (thresh_q),
		.res_valid          (res_valid),
		.res                (res),
		.res_pop            (res_pop)
	);

	assign empty           = !res_valid;
	assign res_pop         = pop && res_valid;
	assign match_found     = res.match;
	assign best_id         = res.id;
	assign best_distance   = res.best;
	assign second_distance = res.second;

`ifndef SYNTHESIS
	// Credit scheme must never overrun the work queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= WQ_CNT_W'(WQ_DEPTH))
		else $error("work queue overrun");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |-> (wq_count < WQ_CNT_W'(WQ_DEPTH)) || wq_pop)
		else $error("push into full work queue");

	// Best never ranks behind second
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> best_distance <= second_distance)
		else $error("best and second distances out of order");
`endif

endmodule

// ===== hw/rtl/hbr_front.sv =====
module hbr_front import hbr_pkg::*; #(
	parameter int DESC_WORDS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  cmd_t                 cmd,
	input  logic [WORD_W-1:0]    word0,
	input  logic [WORD_W-1:0]    word1,
	input  logic [WORD_W-1:0]    word2,
	input  logic [WORD_W-1:0]    word3,
	input  logic [ID_W-1:0]      cand_id,
	input  logic                 last,
	output logic                 wq_push,
	output work_t                wq_item,
	output logic [1:0]           inflight
);

	localparam int USED_WORDS = (DESC_WORDS < IN_WORDS) ? DESC_WORDS : IN_WORDS;

	logic [WORD_W-1:0] in_word [IN_WORDS];
	logic [WORD_W-1:0] query_q [USED_WORDS];
	logic [CNT_W-1:0]  cnt_d   [USED_WORDS];
	logic [CNT_W-1:0]  cnt_s1  [USED_WORDS];
	logic              v_s1;
	cmd_t              kind_s1;
	logic [ID_W-1:0]   id_s1;
	logic              last_s1;
	logic [DIST_W-1:0] sum_d;
	logic              v_s2;
	work_t             item_s2;

	assign in_word[0] = word0;
	assign in_word[1] = word1;
	assign in_word[2] = word2;
	assign in_word[3] = word3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED_WORDS; i++) begin
				query_q[i] <= '0;
			end
		end else if (take && cmd == CMD_LOAD) begin
			for (int i = 0; i < USED_WORDS; i++) begin
				query_q[i] <= in_word[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < USED_WORDS; i++) begin
			cnt_d[i] = pop64(in_word[i] ^ query_q[i]);
		end
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < USED_WORDS; i++) begin
			sum_d = sum_d + DIST_W'(cnt_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= cmd;
			id_s1   <= cand_id;
			last_s1 <= last;
			for (int i = 0; i < USED_WORDS; i++) begin
				cnt_s1[i] <= cnt_d[i];
			end
		end
		if (v_s1) begin
			item_s2.kind  <= kind_s1;
			item_s2.hdist <= sum_d;
			item_s2.id    <= id_s1;
			item_s2.last  <= last_s1;
		end
	end

	assign wq_push  = v_s2;
	assign wq_item  = item_s2;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

// ===== hw/rtl/hbr_queue.sv =====
module hbr_queue import hbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  work_t               din,
	input  logic                pop,
	output work_t               dout,
	output logic [WQ_CNT_W-1:0] count
);

	work_t               mem [WQ_DEPTH];
	logic [WQ_PTR_W-1:0] wr_ptr_q;
	logic [WQ_PTR_W-1:0] rd_ptr_q;
	logic [WQ_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== hw/rtl/hbr_back.sv =====
module hbr_back import hbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wq_empty,
	input  work_t            wq_item,
	output logic             wq_pop,
	input  logic [CFG_W-1:0] ratio_q8,
	input  logic [CFG_W-1:0] distance_threshold,
	output logic             res_valid,
	output result_t          res,
	input  logic             res_pop
);

	logic [DIST_W-1:0] best_q;
	logic [DIST_W-1:0] second_q;
	logic [ID_W-1:0]   id_q;
	logic [1:0]        seen_q;

	logic [DIST_W-1:0] best_d;
	logic [DIST_W-1:0] second_d;
	logic [ID_W-1:0]   id_d;
	logic [1:0]        seen_d;
	logic              take_best;
	logic              is_last;
	logic              fin_move;

	logic              fin_v_s1;
	logic [DIST_W-1:0] fin_best_s1;
	logic [DIST_W-1:0] fin_second_s1;
	logic [ID_W-1:0]   fin_id_s1;
	logic              fin_two_s1;

	logic [2*CFG_W-1:0] lhs;
	logic [2*CFG_W-1:0] rhs;
	logic               ok;

	logic    res_v_q;
	result_t res_q;

	assign is_last  = (wq_item.kind == CMD_CAND) && wq_item.last;
	assign fin_move = fin_v_s1 && (!res_v_q || res_pop);
	assign wq_pop   = !wq_empty && (!is_last || !fin_v_s1 || fin_move);

	// On a tie the second candidate takes the lead; later ones need a strict win
	always_comb begin
		case (seen_q)
			2'd0:    take_best = 1'b1;
			2'd1:    take_best = (wq_item.hdist <= best_q);
			default: take_best = (wq_item.hdist < best_q);
		endcase
		best_d   = best_q;
		second_d = second_q;
		id_d     = id_q;
		if (take_best) begin
			second_d = best_q;
			best_d   = wq_item.hdist;
			id_d     = wq_item.id;
		end else if (wq_item.hdist < second_q) begin
			second_d = wq_item.hdist;
		end
		seen_d = (seen_q == 2'd2) ? seen_q : seen_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= DIST_MAX;
			second_q <= DIST_MAX;
			id_q     <= '0;
			seen_q   <= '0;
			fin_v_s1 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (wq_pop) begin
				if (wq_item.kind == CMD_LOAD || is_last) begin
					best_q   <= DIST_MAX;
					second_q <= DIST_MAX;
					id_q     <= '0;
					seen_q   <= '0;
				end else begin
					best_q   <= best_d;
					second_q <= second_d;
					id_q     <= id_d;
					seen_q   <= seen_d;
				end
			end
			if (wq_pop && is_last) begin
				fin_v_s1 <= 1'b1;
			end else if (fin_move) begin
				fin_v_s1 <= 1'b0;
			end
			if (fin_move) begin
				res_v_q <= 1'b1;
			end else if (res_pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wq_pop && is_last) begin
			fin_best_s1   <= best_d;
			fin_second_s1 <= second_d;
			fin_id_s1     <= id_d;
			fin_two_s1    <= (seen_d == 2'd2);
		end
		if (fin_move) begin
			res_q.match  <= ok;
			res_q.id     <= fin_id_s1;
			res_q.best   <= fin_best_s1;
			res_q.second <= fin_second_s1;
		end
	end

	assign lhs = {1'b0, fin_best_s1, 8'b0};
	assign rhs = ratio_q8 * fin_second_s1;
	assign ok  = fin_two_s1 && (lhs < rhs) && (fin_best_s1 < distance_threshold);

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule
